>>> design/rstri_pkg.sv
// Shared constants, types and helpers of the ring strip triangulator.
package rstri_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = IDX_W + 1;
	localparam int MIN_RING = 3;
	localparam int K_LIMIT = 2 * MAX_VERTICES;
	localparam int K_W = $clog2(K_LIMIT + 1);
	localparam int GUARD_LIMIT = 8 * MAX_VERTICES + 8;
	localparam int GUARD_W = $clog2(GUARD_LIMIT + 1);

	localparam int COORD_W = 20;
	localparam int VERT_W = 2 * COORD_W;
	localparam int CORNER_W = 5;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;

	// Arithmetic widths: a difference, its square, a squared length,
	// a deviation term and the sum of two deviations.
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * COORD_W + 1;
	localparam int DIST_W = SQ_W + 1;
	localparam int OFF2_W = 2 * COORD_W;
	localparam int DEV_W = DIST_W + 3;
	localparam int ACC_W = DEV_W + 1;

	// Cycles from the last read issue until the datapath result is final.
	localparam int PIPE_WAIT = 4;
	localparam int WAIT_W = $clog2(PIPE_WAIT);

	localparam logic [CMD_W-1:0] CMD_LOAD_UPPER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_LOWER = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOO_FEW,
		ST_SEARCH,
		ST_SEARCH_WAIT,
		ST_SEARCH_DONE,
		ST_CHECK,
		ST_STEP,
		ST_READ1,
		ST_READ2,
		ST_FIT_WAIT,
		ST_DECIDE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             wr_upper;
		logic             wr_lower;
		logic [IDX_W-1:0] waddr;
		logic             rd;
		logic [IDX_W-1:0] rd_uaddr;
		logic [IDX_W-1:0] rd_laddr;
		logic             search;
		logic [IDX_W-1:0] tag;
		logic             clr_acc;
		logic             clr_prev;
		logic             latch_prev;
	} dp_cmd_t;

	typedef struct packed {
		logic             worse;
		logic [IDX_W-1:0] best_idx;
		logic             inverted;
	} dp_sts_t;

	// Successor of a ring index, wrapping at the ring length.
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] inc;
		inc = {1'b0, idx} + CNT_W'(1);
		return (inc < cnt) ? inc[IDX_W-1:0] : '0;
	endfunction

endpackage

>>> design/rstri_if.sv
// Valid/ready channel interfaces for input items and result items.
interface rstri_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [rstri_pkg::CMD_W-1:0]           command;
	logic signed [rstri_pkg::COORD_W-1:0]  coord_x;
	logic signed [rstri_pkg::COORD_W-1:0]  coord_y;

	modport source (output valid, output command, output coord_x, output coord_y,
		input ready);
	modport sink (input valid, input command, input coord_x, input coord_y,
		output ready);
endinterface

interface rstri_out_if;
	logic                          valid;
	logic                          ready;
	logic [rstri_pkg::CORNER_W-1:0] corner_first;
	logic [rstri_pkg::CORNER_W-1:0] corner_second;
	logic [rstri_pkg::CORNER_W-1:0] corner_third;
	logic                          last_triangle;
	logic                          too_few;
	logic                          overflow;

	modport source (output valid, output corner_first, output corner_second,
		output corner_third, output last_triangle, output too_few, output overflow,
		input ready);
	modport sink (input valid, input corner_first, input corner_second,
		input corner_third, input last_triangle, input too_few, input overflow,
		output ready);
endinterface

>>> design/rstri_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rstri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/rstri_dp.sv
// Datapath: ring stores, configuration registers, distance pipeline and compares.
module rstri_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rstri_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rstri_pkg::COORD_W-1:0]         cfg_wdata,
	input  logic signed [rstri_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [rstri_pkg::COORD_W-1:0]  coord_y,
	input  rstri_pkg::dp_cmd_t                    cmd,
	output rstri_pkg::dp_sts_t                    sts
);

	localparam int CW = rstri_pkg::COORD_W;
	localparam int IW = rstri_pkg::IDX_W;

	logic signed [CW-1:0] lower_level_q, upper_level_q, offset_q;
	logic signed [rstri_pkg::OFF2_W-1:0] off2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_level_q <= '0;
			upper_level_q <= '0;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rstri_pkg::REG_LOWER_LEVEL: lower_level_q <= cfg_wdata;
				rstri_pkg::REG_UPPER_LEVEL: upper_level_q <= cfg_wdata;
				rstri_pkg::REG_OFFSET:      offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		off2_q <= offset_q * offset_q;
	end

	assign sts.inverted = (upper_level_q < lower_level_q) || offset_q[CW-1];

	logic [rstri_pkg::VERT_W-1:0] wdata, upper_rdata, lower_rdata;
	assign wdata = {coord_x, coord_y};

	rstri_ram #(.WIDTH(rstri_pkg::VERT_W), .DEPTH(rstri_pkg::MAX_VERTICES)) u_upper_ram (
		.clk   (clk),
		.we    (cmd.wr_upper),
		.waddr (cmd.waddr),
		.wdata (wdata),
		.raddr (cmd.rd_uaddr),
		.rdata (upper_rdata)
	);

	rstri_ram #(.WIDTH(rstri_pkg::VERT_W), .DEPTH(rstri_pkg::MAX_VERTICES)) u_lower_ram (
		.clk   (clk),
		.we    (cmd.wr_lower),
		.waddr (cmd.waddr),
		.wdata (wdata),
		.raddr (cmd.rd_laddr),
		.rdata (lower_rdata)
	);

	// Valid, search mode and vertex tag travel alongside the data.
	logic v_s0, v_s1, v_s2, v_s3;
	logic srch_s0, srch_s1, srch_s2, srch_s3;
	logic [IW-1:0] tag_s0, tag_s1, tag_s2, tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s0 <= cmd.rd;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		srch_s0 <= cmd.search;
		srch_s1 <= srch_s0;
		srch_s2 <= srch_s1;
		srch_s3 <= srch_s2;
		tag_s0 <= cmd.tag;
		tag_s1 <= tag_s0;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
	end

	logic signed [CW-1:0] ux, uy, lx, ly;
	assign ux = upper_rdata[rstri_pkg::VERT_W-1:CW];
	assign uy = upper_rdata[CW-1:0];
	assign lx = lower_rdata[rstri_pkg::VERT_W-1:CW];
	assign ly = lower_rdata[CW-1:0];

	logic signed [rstri_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [2*rstri_pkg::DIFF_W-1:0] px, py;
	logic [rstri_pkg::SQ_W-1:0] sqx_s2, sqy_s2;
	logic [rstri_pkg::DIST_W-1:0] dsum, d_s3;
	logic [rstri_pkg::DEV_W-1:0] t_s3, dev;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign dsum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	// The difference is signed; its magnitude is the deviation term.
	assign dev = t_s3[rstri_pkg::DEV_W-1] ? (~t_s3 + rstri_pkg::DEV_W'(1)) : t_s3;

	always_ff @(posedge clk) begin
		dx_s1 <= rstri_pkg::DIFF_W'(ux) - rstri_pkg::DIFF_W'(lx);
		dy_s1 <= rstri_pkg::DIFF_W'(uy) - rstri_pkg::DIFF_W'(ly);
		sqx_s2 <= px[rstri_pkg::SQ_W-1:0];
		sqy_s2 <= py[rstri_pkg::SQ_W-1:0];
		d_s3 <= dsum;
		t_s3 <= {{(rstri_pkg::DEV_W - rstri_pkg::OFF2_W){1'b0}}, off2_q}
			- {{(rstri_pkg::DEV_W - rstri_pkg::DIST_W){1'b0}}, dsum};
	end

	logic [rstri_pkg::ACC_W-1:0] acc_q, prev_q;
	logic [rstri_pkg::DIST_W-1:0] best_q;
	logic [IW-1:0] best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			prev_q <= '0;
		end else begin
			if (cmd.clr_acc) begin
				acc_q <= '0;
			end else if (v_s3 && !srch_s3) begin
				acc_q <= acc_q + {1'b0, dev};
			end
			if (cmd.clr_prev) begin
				prev_q <= '0;
			end else if (cmd.latch_prev) begin
				prev_q <= acc_q;
			end
		end
	end

	// The first strict minimum wins; the first vertex seeds the search.
	always_ff @(posedge clk) begin
		if (v_s3 && srch_s3 && ((tag_s3 == '0) || (d_s3 < best_q))) begin
			best_q <= d_s3;
			best_idx_q <= tag_s3;
		end
	end

	assign sts.worse = acc_q > prev_q;
	assign sts.best_idx = best_idx_q;

endmodule

>>> design/rstri_ctrl.sv
// Controller: ring counts, run sequencing, greedy walk and result register.
module rstri_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [rstri_pkg::CMD_W-1:0]       in_command,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rstri_pkg::CORNER_W-1:0]    out_first,
	output logic [rstri_pkg::CORNER_W-1:0]    out_second,
	output logic [rstri_pkg::CORNER_W-1:0]    out_third,
	output logic                              out_last,
	output logic                              out_too_few,
	output logic                              out_overflow,
	output rstri_pkg::dp_cmd_t                cmd,
	input  rstri_pkg::dp_sts_t                sts
);

	localparam int IW = rstri_pkg::IDX_W;
	localparam int NW = rstri_pkg::CNT_W;
	localparam int KW = rstri_pkg::CORNER_W;

	rstri_pkg::state_t state_q, state_d;
	logic [NW-1:0] ucnt_q, ucnt_d, lcnt_q, lcnt_d, n_q, n_d, m_q, m_d, i_q, i_d;
	logic ovf_q, ovf_d, run_ovf_q, run_ovf_d;
	logic [IW-1:0] u_q, u_d, un_q, un_d, l_q, l_d, ln_q, ln_d, lend_q, lend_d;
	logic upm_q, upm_d, ust_q, ust_d, lst_q, lst_d;
	logic [rstri_pkg::K_W-1:0] k_q, k_d;
	logic [rstri_pkg::GUARD_W-1:0] guard_q, guard_d;
	logic [rstri_pkg::WAIT_W-1:0] wt_q, wt_d;
	logic pend_v_q, pend_v_d;
	logic [KW-1:0] pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;

	logic push, push_last, push_tf;
	logic [KW-1:0] push_a, push_b, push_c;
	logic out_free, accept, keep_going;
	logic [KW-1:0] ta, tb, tc, nu, nl, nln;

	assign accept = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == rstri_pkg::ST_IDLE);

	assign nu = KW'(u_q);
	assign nl = KW'(n_q) + KW'(l_q);
	assign nln = KW'(n_q) + KW'(ln_q);

	// Triangle of the step under decision, in the requested orientation.
	always_comb begin
		if (upm_q) begin
			ta = sts.inverted ? KW'(un_q) : nu;
			tb = nl;
			tc = sts.inverted ? nu : KW'(un_q);
		end else begin
			ta = sts.inverted ? nu : nl;
			tb = nln;
			tc = sts.inverted ? nl : nu;
		end
	end

	assign keep_going = (!ust_q || !lst_q || (u_q != '0) || (l_q != lend_q))
		&& (k_q < rstri_pkg::K_W'(rstri_pkg::K_LIMIT))
		&& (guard_q < rstri_pkg::GUARD_W'(rstri_pkg::GUARD_LIMIT));

	always_comb begin
		state_d = state_q;
		ucnt_d = ucnt_q;
		lcnt_d = lcnt_q;
		n_d = n_q;
		m_d = m_q;
		i_d = i_q;
		ovf_d = ovf_q;
		run_ovf_d = run_ovf_q;
		u_d = u_q;
		un_d = un_q;
		l_d = l_q;
		ln_d = ln_q;
		lend_d = lend_q;
		upm_d = upm_q;
		ust_d = ust_q;
		lst_d = lst_q;
		k_d = k_q;
		guard_d = guard_q;
		wt_d = wt_q;
		pend_v_d = pend_v_q;
		pa_d = pa_q;
		pb_d = pb_q;
		pc_d = pc_q;
		push = 1'b0;
		push_last = 1'b0;
		push_tf = 1'b0;
		push_a = pa_q;
		push_b = pb_q;
		push_c = pc_q;
		cmd = '0;
		cmd.waddr = '0;

		unique case (state_q)
			rstri_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_command)
						rstri_pkg::CMD_LOAD_UPPER: begin
							if (ucnt_q >= NW'(rstri_pkg::MAX_VERTICES)) begin
								ovf_d = 1'b1;
							end else begin
								cmd.wr_upper = 1'b1;
								cmd.waddr = ucnt_q[IW-1:0];
								ucnt_d = ucnt_q + NW'(1);
							end
						end
						rstri_pkg::CMD_LOAD_LOWER: begin
							if (lcnt_q >= NW'(rstri_pkg::MAX_VERTICES)) begin
								ovf_d = 1'b1;
							end else begin
								cmd.wr_lower = 1'b1;
								cmd.waddr = lcnt_q[IW-1:0];
								lcnt_d = lcnt_q + NW'(1);
							end
						end
						rstri_pkg::CMD_RUN: begin
							n_d = ucnt_q;
							m_d = lcnt_q;
							run_ovf_d = ovf_q;
							ucnt_d = '0;
							lcnt_d = '0;
							ovf_d = 1'b0;
							i_d = '0;
							u_d = '0;
							un_d = IW'(1);
							upm_d = 1'b1;
							ust_d = 1'b0;
							lst_d = 1'b0;
							k_d = '0;
							guard_d = '0;
							pend_v_d = 1'b0;
							cmd.clr_prev = 1'b1;
							if ((ucnt_q < NW'(rstri_pkg::MIN_RING))
								|| (lcnt_q < NW'(rstri_pkg::MIN_RING))) begin
								state_d = rstri_pkg::ST_TOO_FEW;
							end else begin
								state_d = rstri_pkg::ST_SEARCH;
							end
						end
						default: ;
					endcase
				end
			end
			rstri_pkg::ST_TOO_FEW: begin
				if (out_free) begin
					push = 1'b1;
					push_last = 1'b1;
					push_tf = 1'b1;
					push_a = '0;
					push_b = '0;
					push_c = '0;
					state_d = rstri_pkg::ST_IDLE;
				end
			end
			rstri_pkg::ST_SEARCH: begin
				// One lower vertex enters the distance pipeline each cycle.
				cmd.rd = 1'b1;
				cmd.search = 1'b1;
				cmd.rd_uaddr = '0;
				cmd.rd_laddr = i_q[IW-1:0];
				cmd.tag = i_q[IW-1:0];
				i_d = i_q + NW'(1);
				if (i_d == m_q) begin
					wt_d = '0;
					state_d = rstri_pkg::ST_SEARCH_WAIT;
				end
			end
			rstri_pkg::ST_SEARCH_WAIT: begin
				wt_d = wt_q + rstri_pkg::WAIT_W'(1);
				if (wt_q == rstri_pkg::WAIT_W'(rstri_pkg::PIPE_WAIT - 1)) begin
					state_d = rstri_pkg::ST_SEARCH_DONE;
				end
			end
			rstri_pkg::ST_SEARCH_DONE: begin
				l_d = sts.best_idx;
				lend_d = sts.best_idx;
				ln_d = rstri_pkg::next_idx(sts.best_idx, m_q);
				state_d = rstri_pkg::ST_STEP;
			end
			rstri_pkg::ST_CHECK: begin
				state_d = keep_going ? rstri_pkg::ST_STEP : rstri_pkg::ST_FLUSH;
			end
			rstri_pkg::ST_STEP: begin
				if (upm_q ? (!ust_q || (u_q != '0)) : (!lst_q || (l_q != lend_q))) begin
					state_d = rstri_pkg::ST_READ1;
				end else begin
					// This ring is back at its start, so the other one moves.
					upm_d = !upm_q;
					guard_d = guard_q + rstri_pkg::GUARD_W'(1);
					state_d = rstri_pkg::ST_CHECK;
				end
			end
			rstri_pkg::ST_READ1: begin
				cmd.rd = 1'b1;
				cmd.clr_acc = 1'b1;
				cmd.rd_uaddr = u_q;
				cmd.rd_laddr = l_q;
				state_d = rstri_pkg::ST_READ2;
			end
			rstri_pkg::ST_READ2: begin
				cmd.rd = 1'b1;
				cmd.rd_uaddr = upm_q ? un_q : u_q;
				cmd.rd_laddr = upm_q ? l_q : ln_q;
				wt_d = '0;
				state_d = rstri_pkg::ST_FIT_WAIT;
			end
			rstri_pkg::ST_FIT_WAIT: begin
				wt_d = wt_q + rstri_pkg::WAIT_W'(1);
				if (wt_q == rstri_pkg::WAIT_W'(rstri_pkg::PIPE_WAIT - 1)) begin
					state_d = rstri_pkg::ST_DECIDE;
				end
			end
			rstri_pkg::ST_DECIDE: begin
				if (sts.worse) begin
					upm_d = !upm_q;
					cmd.latch_prev = 1'b1;
					guard_d = guard_q + rstri_pkg::GUARD_W'(1);
					state_d = rstri_pkg::ST_CHECK;
				end else if (!pend_v_q || out_free) begin
					// The held triangle goes out; the new one waits, since only
					// the end of the walk tells which triangle is the last.
					push = pend_v_q;
					pend_v_d = 1'b1;
					pa_d = ta;
					pb_d = tb;
					pc_d = tc;
					k_d = k_q + rstri_pkg::K_W'(1);
					cmd.latch_prev = 1'b1;
					guard_d = guard_q + rstri_pkg::GUARD_W'(1);
					if (upm_q) begin
						u_d = un_q;
						un_d = rstri_pkg::next_idx(un_q, n_q);
						ust_d = 1'b1;
					end else begin
						l_d = ln_q;
						ln_d = rstri_pkg::next_idx(ln_q, m_q);
						lst_d = 1'b1;
					end
					state_d = rstri_pkg::ST_CHECK;
				end
			end
			rstri_pkg::ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = rstri_pkg::ST_IDLE;
				end else if (out_free) begin
					push = 1'b1;
					push_last = 1'b1;
					pend_v_d = 1'b0;
					state_d = rstri_pkg::ST_IDLE;
				end
			end
			default: state_d = rstri_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rstri_pkg::ST_IDLE;
			ucnt_q <= '0;
			lcnt_q <= '0;
			ovf_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			ucnt_q <= ucnt_d;
			lcnt_q <= lcnt_d;
			ovf_q <= ovf_d;
			pend_v_q <= pend_v_d;
			if (push) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		m_q <= m_d;
		i_q <= i_d;
		run_ovf_q <= run_ovf_d;
		u_q <= u_d;
		un_q <= un_d;
		l_q <= l_d;
		ln_q <= ln_d;
		lend_q <= lend_d;
		upm_q <= upm_d;
		ust_q <= ust_d;
		lst_q <= lst_d;
		k_q <= k_d;
		guard_q <= guard_d;
		wt_q <= wt_d;
		pa_q <= pa_d;
		pb_q <= pb_d;
		pc_q <= pc_d;
		if (push) begin
			out_first <= push_a;
			out_second <= push_b;
			out_third <= push_c;
			out_last <= push_last;
			out_too_few <= push_tf;
			out_overflow <= run_ovf_q;
		end
	end

endmodule

>>> design/ring_strip_triangulator.sv
// Top level of the ring strip triangulator: controller, datapath and checks.
//
//  channel  direction  handshake            payload
//  items    in         items.valid/ready    command, coord_x, coord_y
//  results  out        results.valid/ready  three corners, last_triangle, too_few, overflow
//  cfg      in         cfg_we               cfg_index, cfg_wdata
//
// A run begins after its transfer with the nearest-vertex search over the m lower
// vertices, then walks step by step; each step reads two vertex pairs through the
// four-stage distance pipeline. Reset clears the counts, the overflow flag and the
// control state; the ring stores hold undefined data until loaded. A stalled result
// register holds the walk in its decide state, and items are taken only while no run
// is in progress.
module ring_strip_triangulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rstri_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rstri_pkg::COORD_W-1:0]       cfg_wdata,
	rstri_in_if.sink                            items,
	rstri_out_if.source                         results
);

	rstri_pkg::dp_cmd_t cmd;
	rstri_pkg::dp_sts_t sts;

	rstri_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (items.valid),
		.in_command   (items.command),
		.in_ready     (items.ready),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.out_first    (results.corner_first),
		.out_second   (results.corner_second),
		.out_third    (results.corner_third),
		.out_last     (results.last_triangle),
		.out_too_few  (results.too_few),
		.out_overflow (results.overflow),
		.cmd          (cmd),
		.sts          (sts)
	);

	rstri_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coord_x   (items.coord_x),
		.coord_y   (items.coord_y),
		.cmd       (cmd),
		.sts       (sts)
	);

	// A ring store is never written while the walk reads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd && (cmd.wr_upper || cmd.wr_lower)))
		else $error("ring store written during a read");

	// A load goes to one ring only.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_upper && cmd.wr_lower))
		else $error("both ring stores written at once");

	// A too-few result ends its run and names no vertex.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.too_few) |-> (results.last_triangle
			&& (results.corner_first == '0) && (results.corner_second == '0)
			&& (results.corner_third == '0)))
		else $error("malformed too-few result");

	// The walk never reads while new items are being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> !cmd.rd)
		else $error("datapath read while idle");

endmodule

>>> test/tb.sv
// Testbench of the ring strip triangulator: directed rows, random rings, self-checking.
`timescale 1ns / 1ps

module tb;

	localparam logic [rstri_pkg::CMD_W-1:0] CMD_IDLE_CODE = 2'd3;
	localparam logic [rstri_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 1200;

	typedef struct packed {
		logic [rstri_pkg::CMD_W-1:0]          cmd;
		logic signed [rstri_pkg::COORD_W-1:0] x;
		logic signed [rstri_pkg::COORD_W-1:0] y;
	} vertex_cmd_t;

	typedef struct packed {
		logic [rstri_pkg::CORNER_W-1:0] c1;
		logic [rstri_pkg::CORNER_W-1:0] c2;
		logic [rstri_pkg::CORNER_W-1:0] c3;
		logic                           last;
		logic                           few;
		logic                           ovf;
	} wall_tri_t;

	typedef struct packed {
		vertex_cmd_t item;
		logic        typed;
		wall_tri_t   exp;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rstri_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rstri_pkg::COORD_W-1:0] cfg_wdata;

	rstri_in_if items ();
	rstri_out_if results ();

	ring_strip_triangulator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.items(items.sink),
		.results(results.source)
	);

	// Shadow state of the block.
	longint up_x[rstri_pkg::MAX_VERTICES], up_y[rstri_pkg::MAX_VERTICES];
	longint lo_x[rstri_pkg::MAX_VERTICES], lo_y[rstri_pkg::MAX_VERTICES];
	int up_n, lo_n;
	bit ring_ovf;
	longint lower_lvl, upper_lvl, offset_dist;

	wall_tri_t walk_out[$];
	wall_tri_t expected_tris[$];
	vertex_cmd_t stim[$];
	int errors;
	bit hold_go, hold_done;

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#36_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint sq_len(longint ax, longint ay, longint bx, longint by);
		longint dx, dy;
		dx = ax - bx;
		dy = ay - by;
		return dx * dx + dy * dy;
	endfunction

	function automatic longint dev(longint off2, longint d);
		longint t;
		t = off2 - d;
		return (t < 0) ? -t : t;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Applies one accepted item to the shadow state; a run leaves its triangles in walk_out.
	task automatic apply_item(vertex_cmd_t it);
		int n, m, l, u, un, ln, lend, k, g, i;
		bit ovf, inv, upper_mode, ust, lst;
		longint off2, best, d, cur, prev;
		wall_tri_t t;
		walk_out.delete();
		if (it.cmd == rstri_pkg::CMD_LOAD_UPPER) begin
			if (up_n >= rstri_pkg::MAX_VERTICES) ring_ovf = 1'b1;
			else begin
				up_x[up_n] = longint'(it.x); up_y[up_n] = longint'(it.y); up_n++;
			end
		end else if (it.cmd == rstri_pkg::CMD_LOAD_LOWER) begin
			if (lo_n >= rstri_pkg::MAX_VERTICES) ring_ovf = 1'b1;
			else begin
				lo_x[lo_n] = longint'(it.x); lo_y[lo_n] = longint'(it.y); lo_n++;
			end
		end else if (it.cmd == rstri_pkg::CMD_RUN) begin
			n = up_n; m = lo_n; ovf = ring_ovf;
			up_n = 0; lo_n = 0; ring_ovf = 1'b0;
			if (n < rstri_pkg::MIN_RING || m < rstri_pkg::MIN_RING) begin
				t = '0; t.last = 1'b1; t.few = 1'b1; t.ovf = ovf;
				walk_out = {walk_out, t};
				return;
			end
			inv = (upper_lvl < lower_lvl) || (offset_dist < 0);
			off2 = offset_dist * offset_dist;
			l = 0;
			best = sq_len(lo_x[0], lo_y[0], up_x[0], up_y[0]);
			for (i = 1; i < m; i++) begin
				d = sq_len(lo_x[i], lo_y[i], up_x[0], up_y[0]);
				if (d < best) begin
					best = d; l = i;
				end
			end
			u = 0; un = 1; ln = (l + 1 < m) ? l + 1 : 0; lend = l;
			upper_mode = 1'b1; ust = 1'b0; lst = 1'b0; cur = 0; k = 0; g = 0;
			t = '0;
			t.ovf = ovf;
			do begin
				prev = cur;
				if (upper_mode) begin
					if (!ust || u != 0) begin
						cur = dev(off2, sq_len(up_x[u], up_y[u], lo_x[l], lo_y[l]))
							+ dev(off2, sq_len(up_x[un], up_y[un], lo_x[l], lo_y[l]));
						if (cur > prev) upper_mode = 1'b0;
						else begin
							t.c1 = rstri_pkg::CORNER_W'(inv ? un : u);
							t.c2 = rstri_pkg::CORNER_W'(n + l);
							t.c3 = rstri_pkg::CORNER_W'(inv ? u : un);
							walk_out = {walk_out, t};
							k++;
							u = un; un = (un + 1 < n) ? un + 1 : 0;
							ust = 1'b1;
						end
					end else upper_mode = 1'b0;
				end else begin
					if (!lst || l != lend) begin
						cur = dev(off2, sq_len(up_x[u], up_y[u], lo_x[l], lo_y[l]))
							+ dev(off2, sq_len(up_x[u], up_y[u], lo_x[ln], lo_y[ln]));
						if (cur > prev) upper_mode = 1'b1;
						else begin
							t.c1 = rstri_pkg::CORNER_W'(inv ? u : n + l);
							t.c2 = rstri_pkg::CORNER_W'(n + ln);
							t.c3 = rstri_pkg::CORNER_W'(inv ? n + l : u);
							walk_out = {walk_out, t};
							k++;
							l = ln; ln = (ln + 1 < m) ? ln + 1 : 0;
							lst = 1'b1;
						end
					end else upper_mode = 1'b1;
				end
				g++;
			end while ((!ust || !lst || u != 0 || l != lend) && k < rstri_pkg::K_LIMIT
				&& g < rstri_pkg::GUARD_LIMIT);
			if (k > 0) walk_out[k - 1].last = 1'b1;
		end
	endtask

	// Offers one item and holds it until the transfer, then idles for a random gap.
	task automatic send_item(vertex_cmd_t it, bit typed, wall_tri_t exp);
		int gap;
		items.valid <= 1'b1;
		items.command <= it.cmd;
		items.coord_x <= it.x;
		items.coord_y <= it.y;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		apply_item(it);
		if (typed) expected_tris = {expected_tris, exp};
		else expected_tris = {expected_tris, walk_out};
		gap = gap_len();
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		items.valid <= 1'b0;
		@(posedge clk);
		while (expected_tris.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [rstri_pkg::CFG_IDX_W-1:0] idx,
		logic signed [rstri_pkg::COORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rstri_pkg::REG_LOWER_LEVEL) lower_lvl = longint'(val);
		else if (idx == rstri_pkg::REG_UPPER_LEVEL) upper_lvl = longint'(val);
		else if (idx == rstri_pkg::REG_OFFSET) offset_dist = longint'(val);
	endtask

	function automatic int ring_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom_range(3, 8);
		if (r < 80) return $urandom_range(9, 16);
		if (r < 90) return $urandom_range(17, 19);
		return $urandom_range(0, 2);
	endfunction

	// Builds one load-load-run sequence with interleaved ring loads and occasional idle-code items.
	task automatic build_sequence();
		int nu, nl;
		bit wide;
		int cx, cy;
		vertex_cmd_t it;
		nu = ring_size();
		nl = ring_size();
		wide = ($urandom_range(0, 99) < 25);
		cx = int'($urandom_range(0, 4000)) - 2000;
		cy = int'($urandom_range(0, 4000)) - 2000;
		while (nu > 0 || nl > 0) begin
			if (nl == 0 || (nu > 0 && $urandom_range(0, 1))) begin
				it.cmd = rstri_pkg::CMD_LOAD_UPPER; nu--;
			end else begin
				it.cmd = rstri_pkg::CMD_LOAD_LOWER; nl--;
			end
			if (wide) begin
				it.x = rstri_pkg::COORD_W'($urandom);
				it.y = rstri_pkg::COORD_W'($urandom);
			end else begin
				it.x = rstri_pkg::COORD_W'(cx + int'($urandom_range(0, 600)) - 300);
				it.y = rstri_pkg::COORD_W'(cy + int'($urandom_range(0, 600)) - 300);
			end
			stim.push_front(it);
			if ($urandom_range(0, 49) == 0) begin
				it.cmd = CMD_IDLE_CODE;
				it.x = rstri_pkg::COORD_W'($urandom);
				it.y = rstri_pkg::COORD_W'($urandom);
				stim.push_front(it);
			end
		end
		it.cmd = rstri_pkg::CMD_RUN;
		it.x = rstri_pkg::COORD_W'($urandom);
		it.y = rstri_pkg::COORD_W'($urandom);
		stim.push_front(it);
	endtask

	// Result side: random stalls, one long hold-off, and the scoreboard check.
	always @(posedge clk or negedge arst_n) begin : result_sink
		int stall_left, hold_left;
		wall_tri_t got, exp;
		if (!arst_n) begin
			results.ready <= 1'b0;
			stall_left = 0;
			hold_left = 400;
			hold_done <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				got.c1 = results.corner_first;
				got.c2 = results.corner_second;
				got.c3 = results.corner_third;
				got.last = results.last_triangle;
				got.few = results.too_few;
				got.ovf = results.overflow;
				if (expected_tris.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected triangle %p", got);
				end else begin
					exp = expected_tris.pop_front();
					if (got.c1 !== exp.c1 || got.c2 !== exp.c2 || got.c3 !== exp.c3
						|| got.last !== exp.last || got.few !== exp.few
						|| got.ovf !== exp.ovf) begin
						errors++;
						if (errors <= 10)
							$display("triangle mismatch: expected %p, got %p", exp, got);
					end
				end
			end
			if (hold_go && !hold_done) begin
				results.ready <= 1'b0;
				hold_left--;
				if (hold_left == 0) hold_done <= 1'b1;
			end else if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else begin
				results.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = gap_len();
			end
		end
	end

	table_row_t dir_rows[$];

	function automatic table_row_t mk(logic [rstri_pkg::CMD_W-1:0] c, int x, int y,
		bit typed, wall_tri_t e);
		table_row_t r;
		r.item.cmd = c;
		r.item.x = x[rstri_pkg::COORD_W-1:0];
		r.item.y = y[rstri_pkg::COORD_W-1:0];
		r.typed = typed;
		r.exp = e;
		return r;
	endfunction

	task automatic add_row(logic [rstri_pkg::CMD_W-1:0] c, int x, int y, bit typed,
		wall_tri_t e);
		dir_rows = {dir_rows, mk(c, x, y, typed, e)};
	endtask

	initial begin
		wall_tri_t none, few0;
		vertex_cmd_t it;
		int phase;
		none = '0;
		few0 = '0; few0.last = 1'b1; few0.few = 1'b1;
		errors = 0;
		hold_go = 1'b0;
		up_n = 0; lo_n = 0; ring_ovf = 1'b0;
		lower_lvl = 0; upper_lvl = 0; offset_dist = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		items.valid = 1'b0; items.command = '0; items.coord_x = '0; items.coord_y = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A run right after reset has empty rings.
		add_row(rstri_pkg::CMD_RUN, 0, 0, 1, few0);
		add_row(rstri_pkg::CMD_LOAD_UPPER, 524287, 524287, 0, none);
		add_row(rstri_pkg::CMD_LOAD_UPPER, -524288, -524288, 0, none);
		add_row(rstri_pkg::CMD_LOAD_UPPER, 0, -524288, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 0, 0, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 524287, -524288, 0, none);
		add_row(CMD_IDLE_CODE, -1, -1, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, -524288, 524287, 0, none);
		add_row(rstri_pkg::CMD_RUN, 0, 0, 0, none);
		// Lower ring one vertex short.
		add_row(rstri_pkg::CMD_LOAD_UPPER, 10, 0, 0, none);
		add_row(rstri_pkg::CMD_LOAD_UPPER, 0, 10, 0, none);
		add_row(rstri_pkg::CMD_LOAD_UPPER, -10, 0, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 20, 0, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 0, 20, 0, none);
		add_row(rstri_pkg::CMD_RUN, 0, 0, 1, few0);
		add_row(rstri_pkg::CMD_LOAD_UPPER, 5, 5, 0, none);
		add_row(rstri_pkg::CMD_LOAD_UPPER, 6, -5, 0, none);
		add_row(rstri_pkg::CMD_LOAD_UPPER, -7, 0, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 9, 1, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 1, -9, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, -9, 2, 0, none);
		add_row(rstri_pkg::CMD_LOAD_LOWER, 0, 9, 0, none);
		add_row(rstri_pkg::CMD_RUN, 0, 0, 0, none);

		write_reg(rstri_pkg::REG_OFFSET, 20'sd12);
		write_reg(REG_SPARE, 20'sd77);
		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);
		drain();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(rstri_pkg::REG_LOWER_LEVEL, 20'sh80000);
					write_reg(rstri_pkg::REG_UPPER_LEVEL, 20'sd524287);
					write_reg(rstri_pkg::REG_OFFSET, 20'sd524287);
				end
				1: begin
					write_reg(rstri_pkg::REG_LOWER_LEVEL, 20'sd524287);
					write_reg(rstri_pkg::REG_UPPER_LEVEL, 20'sh80000);
					write_reg(rstri_pkg::REG_OFFSET, 20'sd150);
				end
				2: begin
					write_reg(rstri_pkg::REG_LOWER_LEVEL, 20'sd0);
					write_reg(rstri_pkg::REG_UPPER_LEVEL, 20'sd100);
					write_reg(rstri_pkg::REG_OFFSET, 20'sh80000);
				end
				3: begin
					write_reg(rstri_pkg::REG_LOWER_LEVEL, 20'sd0);
					write_reg(rstri_pkg::REG_UPPER_LEVEL, 20'sd0);
					write_reg(rstri_pkg::REG_OFFSET, 20'sd0);
				end
				default: begin
					write_reg(rstri_pkg::REG_LOWER_LEVEL, rstri_pkg::COORD_W'($urandom));
					write_reg(rstri_pkg::REG_UPPER_LEVEL, rstri_pkg::COORD_W'($urandom));
					write_reg(rstri_pkg::REG_OFFSET,
						rstri_pkg::COORD_W'(-int'($urandom_range(0, 400))));
				end
			endcase
			stim.delete();
			while (stim.size() < 18) build_sequence();
			// The receiver holds off once while the sender keeps offering items.
			if (phase == 0) hold_go <= 1'b1;
			while (stim.size() > 0) begin
				it = stim.pop_back();
				send_item(it, 1'b0, none);
			end
			drain();
		end

		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
design/rstri_pkg.sv
design/rstri_if.sv
design/rstri_ram.sv
design/rstri_dp.sv
design/rstri_ctrl.sv
design/ring_strip_triangulator.sv
test/tb.sv
